@@ src/assert_macros.svh @@
// shared assertion macros for the edge period statistics block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property, checked on every rising edge out of reset
`define EPFS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen out of reset
`define EPFS_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ src/epfs_pkg.sv @@
`default_nettype none

package epfs_pkg;

  // default scaling of the frequency result
  localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;
  localparam int unsigned FRAC_BITS_DEF        = 12;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // width of the shared divider
  localparam int unsigned DIV_W = 32;

  // input operation codes
  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [31:0] timestamp_us;
  } in_word_t;

  typedef struct packed {
    logic [31:0] freq_min;
    logic [31:0] freq_mean;
    logic [31:0] freq_max;
    logic [31:0] sample_count;
  } out_word_t;

  // classified work handed from front to back
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_SAMPLE = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] period;
  } cmd_word_t;

  // divider request: {hi, lo} / divisor, quotient saturates at all ones
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] hi;
    logic [DIV_W-1:0] lo;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

@@ src/epfs_front.sv @@
`default_nettype none

module epfs_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire epfs_pkg::in_word_t   in_word,
  input  wire logic                 q_full,
  output logic                      q_push,
  output epfs_pkg::cmd_word_t       q_word
);
  import epfs_pkg::*;

  logic [31:0] last_edge_r, last_edge_nxt;
  logic        first_r, first_nxt;
  logic [31:0] period;

  // classify the word and form the wrapping period
  always_comb begin
    q_push        = push && !q_full;
    period        = in_word.timestamp_us - last_edge_r;
    q_word.period = period;
    if (in_word.operation == OP_CLEAR) begin
      q_word.kind = CMD_CLEAR;
    end else if (first_r || period == '0) begin
      q_word.kind = CMD_REPORT;
    end else begin
      q_word.kind = CMD_SAMPLE;
    end
  end

  // edge timestamp tracking
  always_comb begin
    last_edge_nxt = last_edge_r;
    first_nxt     = first_r;
    if (q_push) begin
      if (in_word.operation == OP_CLEAR) begin
        last_edge_nxt = '0;
        first_nxt     = 1'b1;
      end else begin
        last_edge_nxt = in_word.timestamp_us;
        first_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r <= '0;
      first_r     <= 1'b1;
    end else begin
      last_edge_r <= last_edge_nxt;
      first_r     <= first_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/epfs_fifo.sv @@
`default_nettype none
`include "assert_macros.svh"

module epfs_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire epfs_pkg::cmd_word_t  wr_word,
  output logic                      full,
  input  wire logic                 rd_en,
  output epfs_pkg::cmd_word_t       rd_word,
  output logic                      empty
);
  import epfs_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_word_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_word = mem[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_word;
    end
  end

  `EPFS_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
  `EPFS_ASSERT(a_count_step, clk, rst_n, (do_wr && !do_rd) |=> (count_r == $past(count_r) + 1'b1), "fill count did not step")
  `EPFS_NEVER(a_ptr_skew, clk, rst_n, empty && (wr_ptr_r != rd_ptr_r), "pointers apart while empty")

endmodule

`default_nettype wire

@@ src/epfs_div.sv @@
`default_nettype none
`include "assert_macros.svh"

module epfs_div (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire epfs_pkg::div_req_t                  req,
  output logic                                     done,
  output logic [epfs_pkg::DIV_W-1:0]               quotient
);
  import epfs_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_W:0]   shifted;
  logic             fits;

  assign done     = done_r;
  assign quotient = quo_r;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted  = {rem_r, quo_r[DIV_W-1]};
    fits     = (shifted >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      dvs_nxt = req.divisor;
      cnt_nxt = '0;
      if (req.hi >= req.divisor) begin
        // quotient would not fit: saturate
        quo_nxt  = '1;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = req.hi;
        quo_nxt  = req.lo;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = fits ? DIV_W'(shifted - {1'b0, dvs_r}) : shifted[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  `EPFS_NEVER(a_done_busy, clk, rst_n, done_r && busy_r, "divider done while still busy")
  `EPFS_NEVER(a_start_busy, clk, rst_n, req.start && busy_r, "divider restarted mid-run")

endmodule

`default_nettype wire

@@ src/epfs_back.sv @@
`default_nettype none
`include "assert_macros.svh"

module epfs_back #(
  parameter int unsigned TICKS_PER_SECOND = epfs_pkg::TICKS_PER_SECOND_DEF,
  parameter int unsigned FRAC_BITS        = epfs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire epfs_pkg::cmd_word_t  q_word,
  input  wire logic                 q_empty,
  output logic                      q_pop,
  output epfs_pkg::div_req_t        div_req,
  input  wire logic                 div_done,
  input  wire logic [31:0]          div_quo,
  output epfs_pkg::out_word_t       out_word,
  output logic                      empty,
  input  wire logic                 pop
);
  import epfs_pkg::*;

  // scaled numerator of the frequency division, fits 32 bits over the range
  localparam logic [63:0] NUM64    = 64'(TICKS_PER_SECOND) << FRAC_BITS;
  localparam logic [31:0] FREQ_NUM = NUM64[31:0];

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FDIV   = 5'b00010,
    S_MSTART = 5'b00100,
    S_MDIV   = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] min_r, min_nxt;
  logic [31:0] max_r, max_nxt;
  logic [63:0] sum_r, sum_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] mean_r, mean_nxt;
  out_word_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [64:0] sum_add;
  logic        out_free;

  assign empty    = !out_valid_r;
  assign out_word = out_r;
  assign out_free = !out_valid_r || pop;
  assign sum_add  = {1'b0, sum_r} + {33'd0, div_quo};

  // sequencer: clear or report directly, or frequency division, statistics update, mean division, report
  always_comb begin
    state_nxt     = state_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    mean_nxt      = mean_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !pop;
    q_pop         = 1'b0;
    div_req       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_word.kind)
            CMD_CLEAR: begin
              min_nxt   = '0;
              max_nxt   = '0;
              sum_nxt   = '0;
              count_nxt = '0;
              mean_nxt  = '0;
              state_nxt = S_OUT;
            end
            CMD_SAMPLE: begin
              div_req.start   = 1'b1;
              div_req.hi      = '0;
              div_req.lo      = FREQ_NUM;
              div_req.divisor = q_word.period;
              state_nxt       = S_FDIV;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_FDIV: begin
        if (div_done) begin
          if (count_r == '0) begin
            min_nxt = div_quo;
            max_nxt = div_quo;
          end else begin
            if (div_quo < min_r) begin
              min_nxt = div_quo;
            end
            if (div_quo > max_r) begin
              max_nxt = div_quo;
            end
          end
          if (count_r != '1) begin
            sum_nxt   = sum_add[64] ? '1 : sum_add[63:0];
            count_nxt = count_r + 1'b1;
          end
          state_nxt = S_MSTART;
        end
      end
      S_MSTART: begin
        div_req.start   = 1'b1;
        div_req.hi      = sum_r[63:32];
        div_req.lo      = sum_r[31:0];
        div_req.divisor = count_r;
        state_nxt       = S_MDIV;
      end
      S_MDIV: begin
        if (div_done) begin
          mean_nxt  = div_quo;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_nxt.freq_min     = min_r;
          out_nxt.freq_mean    = mean_r;
          out_nxt.freq_max     = max_r;
          out_nxt.sample_count = count_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      min_r       <= '0;
      max_r       <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      mean_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      mean_r      <= mean_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  `EPFS_ASSERT(a_done_state, clk, rst_n, div_done |-> (state_r == S_FDIV || state_r == S_MDIV), "divider result with no division pending")
  `EPFS_ASSERT(a_min_max, clk, rst_n, (count_r != '0) |-> (min_r <= max_r), "minimum above maximum")
  `EPFS_ASSERT(a_zero_stats, clk, rst_n, (count_r == '0) |-> (sum_r == '0 && mean_r == '0), "statistics not cleared with no samples")

endmodule

`default_nettype wire

@@ src/edge_period_frequency_stats.sv @@
// edge period frequency statistics
// input queue side: drive in_word and raise push; the word is taken at a rising
//   edge with push high and full low. operation 0 reports a rising edge with its
//   microsecond timestamp, operation 1 clears the statistics.
// result queue side: while empty is low out_word holds the oldest result
//   (minimum, mean, maximum, sample count); pop high with empty low takes it.
// every input word gives exactly one result word, in order.
// a clear, a first edge or a zero period goes straight to its report once it is
//   taken; an edge that forms a period makes two passes of the shared 32-step
//   divider (frequency, then mean) at one quotient bit per cycle, and the mean
//   pass stops at once with a saturated quotient when the mean would not fit.
// one word in progress in the back end at a time, so it takes no new word until
//   the last one has reported; a two-word queue between the classifying
//   front end and the back end absorbs short bursts.
// when the receiver stalls the finished result waits in the output register, the
//   back end holds its next result and the queue fills, then full rises.
// reset (rst_n low, synchronous) empties both queues, forgets the last edge and
//   sets all statistics to zero; no clearing pass is needed.
`default_nettype none

module edge_period_frequency_stats #(
  parameter int unsigned TICKS_PER_SECOND = epfs_pkg::TICKS_PER_SECOND_DEF,
  parameter int unsigned FRAC_BITS        = epfs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  output logic                      full,
  input  wire epfs_pkg::in_word_t   in_word,
  output logic                      empty,
  input  wire logic                 pop,
  output epfs_pkg::out_word_t       out_word
);
  import epfs_pkg::*;

  logic        q_push;
  logic        q_pop;
  logic        q_empty;
  cmd_word_t   q_wr_word;
  cmd_word_t   q_rd_word;
  div_req_t    div_req;
  logic        div_done;
  logic [31:0] div_quo;

  // classify and timestamp
  epfs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_word (in_word),
    .q_full  (full),
    .q_push  (q_push),
    .q_word  (q_wr_word)
  );

  // decoupling queue
  epfs_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_word (q_wr_word),
    .full    (full),
    .rd_en   (q_pop),
    .rd_word (q_rd_word),
    .empty   (q_empty)
  );

  // shared serial divider
  epfs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // statistics and result register
  epfs_back #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .FRAC_BITS        (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_word   (q_rd_word),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .div_req  (div_req),
    .div_done (div_done),
    .div_quo  (div_quo),
    .out_word (out_word),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import epfs_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned RANDOM_WORDS = 1500;
  localparam int unsigned CALM_TAIL    = 150;
  localparam int unsigned SETTLE       = 120;
  localparam logic [63:0] FREQ_SCALE   = 64'(TICKS_PER_SECOND_DEF) << FRAC_BITS_DEF;

  typedef struct {
    in_word_t word;
    bit       drain;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full;
  logic      empty;
  in_word_t  in_word = '0;
  out_word_t out_word;

  stim_t     pending[$];
  out_word_t stats_due[$];
  out_word_t want;

  // predictor state
  logic [31:0] prev_edge_us;
  bit          first_edge_due;
  logic [31:0] lo_freq;
  logic [31:0] hi_freq;
  logic [63:0] freq_total;
  logic [31:0] sample_cnt;

  logic [31:0] stim_us;
  bit          in_fire;
  bit          out_fire;
  bit          calm_tail;
  int unsigned src_gap;
  int unsigned sink_stall;
  int unsigned cycles;
  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned n_clears;
  int unsigned n_samples;
  int unsigned n_zero;

  edge_period_frequency_stats dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_word (in_word),
    .empty   (empty),
    .pop     (pop),
    .out_word(out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // period in microseconds to frequency, truncated, saturating
  function automatic logic [31:0] freq_of_period(logic [31:0] period);
    logic [63:0] q;
    q = FREQ_SCALE / {32'd0, period};
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    return q[31:0];
  endfunction

  function automatic void clear_stats();
    prev_edge_us   = '0;
    first_edge_due = 1'b1;
    lo_freq        = '0;
    hi_freq        = '0;
    freq_total     = '0;
    sample_cnt     = '0;
  endfunction

  // advance the statistics by one word and return the reported values
  function automatic out_word_t stats_after_word(in_word_t w);
    logic [31:0] period;
    logic [31:0] f;
    logic [63:0] s;
    logic [63:0] mean;
    out_word_t   r;
    if (w.operation == OP_CLEAR) begin
      clear_stats();
      n_clears++;
    end else if (first_edge_due) begin
      prev_edge_us   = w.timestamp_us;
      first_edge_due = 1'b0;
    end else begin
      period       = w.timestamp_us - prev_edge_us;
      prev_edge_us = w.timestamp_us;
      if (period == 0) begin
        n_zero++;
      end else begin
        f = freq_of_period(period);
        n_samples++;
        if (sample_cnt == 0) begin
          lo_freq = f;
          hi_freq = f;
        end else begin
          if (f < lo_freq) lo_freq = f;
          if (f > hi_freq) hi_freq = f;
        end
        // sum and count freeze together once the count is saturated
        if (sample_cnt != 32'hFFFF_FFFF) begin
          s          = freq_total + {32'd0, f};
          freq_total = (s < freq_total) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
          sample_cnt++;
        end
      end
    end
    mean = '0;
    if (sample_cnt != 0) mean = freq_total / {32'd0, sample_cnt};
    if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
    r.freq_min     = lo_freq;
    r.freq_mean    = mean[31:0];
    r.freq_max     = hi_freq;
    r.sample_count = sample_cnt;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
    if (got !== exp_val) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0d got %0d", $realtime, name, exp_val, got);
    end
  endtask

  // acceptance, prediction and result checking at the rising edge
  always @(posedge clk) begin
    cycles++;
    in_fire   = rst_n && push && !full;
    out_fire  = rst_n && pop && !empty;
    calm_tail = pending.size() < CALM_TAIL;
    if (in_fire) stats_due.push_back(stats_after_word(in_word));
    if (out_fire) begin
      if (stats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing expected", $realtime);
      end else begin
        want = stats_due.pop_front();
        words_checked++;
        check_field("freq_min", out_word.freq_min, want.freq_min);
        check_field("freq_mean", out_word.freq_mean, want.freq_mean);
        check_field("freq_max", out_word.freq_max, want.freq_max);
        check_field("sample_count", out_word.sample_count, want.sample_count);
      end
    end
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, stats_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // driver: next word from the pending queue, with idle bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!push || in_fire) begin
      if (src_gap != 0) begin
        src_gap--;
        push <= 1'b0;
      end else if (pending.size() == 0) begin
        push <= 1'b0;
      end else if (pending[0].drain && stats_due.size() != 0) begin
        // hold off until every outstanding result has been collected
        push <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 11) == 0) begin
        src_gap = $urandom_range(1, 19) - 1;
        push <= 1'b0;
      end else begin
        in_word <= pending[0].word;
        push    <= 1'b1;
        void'(pending.pop_front());
      end
    end
  end

  // receiver: pop with random stall bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (sink_stall != 0) begin
      sink_stall--;
      pop <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
      sink_stall = $urandom_range(1, 19) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic queue_word(logic op, logic [31:0] ts, bit drain);
    stim_t s;
    s.word.operation    = op;
    s.word.timestamp_us = ts;
    s.drain             = drain;
    pending.push_back(s);
  endtask

  task automatic queue_edge(logic [31:0] ts, bit drain = 1'b0);
    stim_us = ts;
    queue_word(OP_EDGE, ts, drain);
  endtask

  task automatic queue_period(logic [31:0] period);
    queue_edge(stim_us + period);
  endtask

  initial begin
    int unsigned pick;
    clear_stats();

    // directed: first edge, zero period, extreme periods, wrap and clears
    queue_edge(32'd0);
    queue_edge(32'd0);
    queue_edge(32'd1);
    queue_edge(32'd0);
    queue_edge(32'd1000000);
    queue_word(OP_CLEAR, 32'hFFFF_FFFF, 1'b1);
    queue_edge(32'hFFFF_FFFF);
    queue_edge(32'd2);
    queue_edge(32'd2);
    queue_period(32'd4096);
    queue_period(32'd4096001);
    queue_period(32'd4096000000);
    queue_period(32'd4096000001);
    queue_word(OP_CLEAR, 32'd0, 1'b0);
    queue_word(OP_CLEAR, 32'hA5A5_5A5A, 1'b0);
    queue_edge(32'h8000_0000);
    queue_edge(32'h7FFF_FFFF);
    queue_edge(32'hAAAA_AAAA);
    queue_edge(32'h5555_5555);
    queue_period(32'h8000_0000);
    queue_period(32'd2);
    queue_period(32'd3);

    // random: mostly plausible edge trains, some noise, zero periods and clears
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(0, 99);
      if (i == RANDOM_WORDS / 2)
        queue_edge(stim_us + $urandom_range(1, 5000), 1'b1);
      else if (pick < 3)
        queue_word(OP_CLEAR, $urandom, 1'b0);
      else if (pick < 7)
        queue_edge($urandom);
      else if (pick < 11)
        queue_period(32'd0);
      else if (pick < 40)
        queue_period($urandom_range(1, 64));
      else if (pick < 75)
        queue_period($urandom_range(1, 1000000));
      else if (pick < 90)
        queue_period($urandom_range(1000000, 32'hFFFF_FFFF));
      else
        queue_period($urandom);
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (pending.size() != 0 || push) @(posedge clk);
    while (stats_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("checked %0d result words: %0d frequency samples, %0d zero periods, %0d clears",
             words_checked, n_samples, n_zero, n_clears);
    $display("idle and stall bursts on both sides, one full drain before a word");
    if (mismatches == 0 && stats_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, stats_due.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
